// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the interval sampler with ping-pong store.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int CHANNELS  = 4;
	localparam int BUF_DEPTH = 64;

	localparam int CH_W     = 2;
	localparam int SLOT_W   = 6;
	localparam int SAMPLE_W = 10;
	localparam int IV_W     = 17;
	localparam int IDX_W    = 3;
	localparam int ADDR_W   = CH_W + 1 + SLOT_W;
	localparam int DEPTH    = CHANNELS * 2 * BUF_DEPTH;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MASK = 3'd0;
	localparam logic [IDX_W-1:0] REG_IV0  = 3'd1;

	// Request opcodes and result kinds.
	localparam logic OP_TICK     = 1'b0;
	localparam logic OP_READ     = 1'b1;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUF_DEPTH - 1);

	typedef logic [SAMPLE_W-1:0] sample_t;

	// Channel update command from the sequencer.
	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] ch;
	} chan_step_t;

	// Firing status of every channel and next write location of the selected channel.
	typedef struct packed {
		logic [CHANNELS-1:0] fire_vec;
		logic                half;
		logic [SLOT_W-1:0]   slot;
		logic                rdy;
		logic                rdy_half;
	} chan_info_t;

endpackage

// ===== rtl/core/sps_in_if.sv =====
// ----------------------------------------------------------------------------
// sps_in_if
// Request channel: ticks with samples and store reads.
// ----------------------------------------------------------------------------
interface sps_in_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [sps_pkg::SAMPLE_W-1:0]   sample_ch0;
	logic [sps_pkg::SAMPLE_W-1:0]   sample_ch1;
	logic [sps_pkg::SAMPLE_W-1:0]   sample_ch2;
	logic [sps_pkg::SAMPLE_W-1:0]   sample_ch3;
	logic [sps_pkg::CH_W-1:0]       read_channel;
	logic                           read_half;
	logic [sps_pkg::SLOT_W-1:0]     read_slot;

	modport source (output valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		read_channel, read_half, read_slot, input ready);
	modport sink (input valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		read_channel, read_half, read_slot, output ready);
endinterface

// ===== rtl/core/sps_out_if.sv =====
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: sample reports and read data.
// ----------------------------------------------------------------------------
interface sps_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [sps_pkg::CH_W-1:0]       channel;
	logic                           half;
	logic [sps_pkg::SLOT_W-1:0]     slot;
	logic [sps_pkg::SAMPLE_W-1:0]   value;
	logic                           half_ready;
	logic                           ready_half;
	logic                           last;

	modport source (output valid, kind, channel, half, slot, value, half_ready, ready_half,
		last, input ready);
	modport sink (input valid, kind, channel, half, slot, value, half_ready, ready_half,
		last, output ready);
endinterface

// ===== rtl/core/sps_store.sv =====
// ----------------------------------------------------------------------------
// sps_store
// Sample store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sps_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [sps_pkg::ADDR_W-1:0]    waddr,
	input  sps_pkg::sample_t              wdata,
	input  logic                          re,
	input  logic [sps_pkg::ADDR_W-1:0]    raddr,
	output sps_pkg::sample_t              rdata
);

	sps_pkg::sample_t mem_q [sps_pkg::DEPTH];
	sps_pkg::sample_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sps_chan.sv =====
// ----------------------------------------------------------------------------
// sps_chan
// Configuration registers and per-channel timer, write position and half.
// ----------------------------------------------------------------------------
module sps_chan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sps_pkg::IDX_W-1:0]     cfg_index,
	input  logic [sps_pkg::IV_W-1:0]      cfg_data,
	input  sps_pkg::chan_step_t           step,
	output sps_pkg::chan_info_t           info
);

	logic [sps_pkg::CHANNELS-1:0] mask_q;
	logic [sps_pkg::IV_W-1:0]     iv_q   [sps_pkg::CHANNELS];
	logic [sps_pkg::IV_W-1:0]     cd_q   [sps_pkg::CHANNELS];
	logic [sps_pkg::SLOT_W-1:0]   wpos_q [sps_pkg::CHANNELS];
	logic [sps_pkg::CHANNELS-1:0] half_q;

	logic [sps_pkg::CHANNELS-1:0] act;
	logic [sps_pkg::CHANNELS-1:0] fire;
	logic                         wrap;
	logic [sps_pkg::SLOT_W-1:0]   slot_n;

	// A channel takes part when enabled with a nonzero interval.
	always_comb begin
		for (int c = 0; c < sps_pkg::CHANNELS; c++) begin
			act[c]  = mask_q[c] && (iv_q[c] != '0);
			fire[c] = act[c] && (cd_q[c] <= sps_pkg::IV_W'(1));
		end
	end

	// Next write location of the selected channel.
	assign wrap   = (wpos_q[step.ch] == sps_pkg::SLOT_LAST);
	assign slot_n = wrap ? '0 : wpos_q[step.ch] + sps_pkg::SLOT_W'(1);

	always_comb begin
		info.fire_vec = fire;
		info.slot     = slot_n;
		info.half     = wrap ? ~half_q[step.ch] : half_q[step.ch];
		info.rdy      = wrap;
		info.rdy_half = wrap ? half_q[step.ch] : 1'b0;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int c = 0; c < sps_pkg::CHANNELS; c++) begin
				iv_q[c] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == sps_pkg::REG_MASK) begin
				mask_q <= cfg_data[sps_pkg::CHANNELS-1:0];
			end
			for (int c = 0; c < sps_pkg::CHANNELS; c++) begin
				if (cfg_index == sps_pkg::REG_IV0 + sps_pkg::IDX_W'(c)) begin
					iv_q[c] <= cfg_data;
				end
			end
		end
	end

	// Channel state update for the channel that the sequencer visits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= '0;
			for (int c = 0; c < sps_pkg::CHANNELS; c++) begin
				cd_q[c]   <= '0;
				wpos_q[c] <= '0;
			end
		end else if (step.en && act[step.ch]) begin
			if (fire[step.ch]) begin
				wpos_q[step.ch] <= slot_n;
				half_q[step.ch] <= info.half;
				cd_q[step.ch]   <= iv_q[step.ch];
			end else begin
				cd_q[step.ch] <= cd_q[step.ch] - sps_pkg::IV_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/interval_sampler_pingpong_store_core.sv =====
// ----------------------------------------------------------------------------
// interval_sampler_pingpong_store_core
// Interval sampler writing per-channel samples into a ping-pong store.
// ----------------------------------------------------------------------------
// A tick request makes one step per channel in turn, a read a single step,
// one step per cycle while the output register can take it. Each result
// sits in the output register in the cycle after its step. Throughput is set
// by the single store write port and the single result port.
// Reset clears configuration, timers, write positions and half selects; the
// sample store is not cleared and needs no sweep.
module interval_sampler_pingpong_store_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sps_pkg::IDX_W-1:0]     cfg_index,
	input  logic [sps_pkg::IV_W-1:0]      cfg_data,
	sps_in_if.sink                        item,
	sps_out_if.source                     result
);

	// Sequencer stage.
	logic                         valid_s1;
	logic                         opcode_s1;
	sps_pkg::sample_t             sample_s1 [sps_pkg::CHANNELS];
	logic [sps_pkg::CH_W-1:0]     rch_s1;
	logic                         rhalf_s1;
	logic [sps_pkg::SLOT_W-1:0]   rslot_s1;
	logic [sps_pkg::CH_W-1:0]     ch_s1;

	// Output register.
	logic                         out_valid_q;
	logic                         from_mem_q;
	logic                         kind_q;
	logic [sps_pkg::CH_W-1:0]     channel_q;
	logic                         half_q;
	logic [sps_pkg::SLOT_W-1:0]   slot_q;
	sps_pkg::sample_t             value_q;
	logic                         half_ready_q;
	logic                         ready_half_q;
	logic                         last_q;

	logic                         out_free;
	logic                         step;
	logic                         step_done;
	logic                         is_read;
	logic                         fire_now;
	logic                         later_fire;
	logic                         accept;
	sps_pkg::chan_step_t          cstep;
	sps_pkg::chan_info_t          cinfo;
	sps_pkg::sample_t             rdata;
	logic [sps_pkg::ADDR_W-1:0]   waddr;
	logic [sps_pkg::ADDR_W-1:0]   raddr;

	// Step control: one step per cycle while the output register can take it.
	assign out_free  = !out_valid_q || result.ready;
	assign step      = valid_s1 && out_free;
	assign is_read   = (opcode_s1 == sps_pkg::OP_READ);
	assign step_done = step && (is_read || (ch_s1 == sps_pkg::CH_LAST));
	assign item.ready = !valid_s1 || step_done;
	assign accept    = item.valid && item.ready;

	assign cstep.en = step && !is_read;
	assign cstep.ch = ch_s1;

	sps_chan u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (cstep),
		.info      (cinfo)
	);

	assign fire_now = cinfo.fire_vec[ch_s1];

	// Any firing channel after the current one means this result is not last.
	always_comb begin
		later_fire = 1'b0;
		for (int c = 0; c < sps_pkg::CHANNELS; c++) begin
			if (sps_pkg::CH_W'(c) > ch_s1) begin
				later_fire = later_fire | cinfo.fire_vec[c];
			end
		end
	end

	assign waddr = {ch_s1, cinfo.half, cinfo.slot};
	assign raddr = {rch_s1, rhalf_s1, rslot_s1};

	sps_store u_store (
		.clk   (clk),
		.we    (cstep.en && fire_now),
		.waddr (waddr),
		.wdata (sample_s1[ch_s1]),
		.re    (step && is_read),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ch_s1    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			ch_s1    <= '0;
		end else if (step_done) begin
			valid_s1 <= 1'b0;
		end else if (step) begin
			ch_s1 <= ch_s1 + sps_pkg::CH_W'(1);
		end
	end

	// Request payload capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1    <= item.opcode;
			sample_s1[0] <= item.sample_ch0;
			sample_s1[1] <= item.sample_ch1;
			sample_s1[2] <= item.sample_ch2;
			sample_s1[3] <= item.sample_ch3;
			rch_s1       <= item.read_channel;
			rhalf_s1     <= item.read_half;
			rslot_s1     <= item.read_slot;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && (is_read || fire_now)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (step && is_read) begin
			from_mem_q   <= 1'b1;
			kind_q       <= sps_pkg::KIND_READ;
			channel_q    <= rch_s1;
			half_q       <= rhalf_s1;
			slot_q       <= rslot_s1;
			half_ready_q <= 1'b0;
			ready_half_q <= 1'b0;
			last_q       <= 1'b1;
		end else if (step && fire_now) begin
			from_mem_q   <= 1'b0;
			kind_q       <= sps_pkg::KIND_SAMPLE;
			channel_q    <= ch_s1;
			half_q       <= cinfo.half;
			slot_q       <= cinfo.slot;
			value_q      <= sample_s1[ch_s1];
			half_ready_q <= cinfo.rdy;
			ready_half_q <= cinfo.rdy_half;
			last_q       <= !later_fire;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = kind_q;
	assign result.channel    = channel_q;
	assign result.half       = half_q;
	assign result.slot       = slot_q;
	assign result.value      = from_mem_q ? rdata : value_q;
	assign result.half_ready = half_ready_q;
	assign result.ready_half = ready_half_q;
	assign result.last       = last_q;

endmodule
